### rtl/core/qnl_pkg.sv
// Package for the quaternion nlerp pipeline: fixed-point widths, stage counts and
// the lane status struct. No dependencies.
package qnl_pkg;

   localparam int FRAC_BITS = 14;

   // magnitude of a blended component is at most 2^30
   localparam int MAG_W  = 31;
   localparam int MAG2_W = 2 * MAG_W;
   // sum of four squares
   localparam int SUM_W  = 63;
   // quotient bits of 4*mag^2*2^(2F) / S, which never exceeds 2^(2F+2)
   localparam int QUO_W  = 2 * FRAC_BITS + 3;
   // root bits of the quotient
   localparam int ROOT_W = (QUO_W + 1) / 2;
   // remainder width of the divider
   localparam int DREM_W = SUM_W + QUO_W - 1;
   // remainder width of the square root
   localparam int SREM_W = QUO_W + 2;
   // register stages ahead of the output register
   localparam int PIPE_D = 6 + QUO_W + ROOT_W;

   localparam logic [16:0] ONE_RAW = 17'((64'd1 << FRAC_BITS) > 64'd32767 ?
                                         64'd32767 : (64'd1 << FRAC_BITS));
   localparam logic [15:0] ONE_Q   = ONE_RAW[15:0];

   typedef struct packed {
      logic [MAG2_W-1:0] mag2;
      logic              neg;
   } lane_mag_type;

endpackage

### rtl/core/qnl_blend_lane.sv
// One component lane: dot product term, hemisphere fix, blend and square.
// Depends on qnl_pkg.
module qnl_blend_lane (
   input  logic                        clock,
   input  logic                        en,
   input  logic signed [15:0]          a,
   input  logic signed [15:0]          b,
   input  logic [15:0]                 blend,
   input  logic                        flip,
   output logic signed [31:0]          prod,
   output logic [qnl_pkg::MAG2_W-1:0]  mag2_early,
   output qnl_pkg::lane_mag_type       result
);
   import qnl_pkg::*;

   logic signed [15:0] a1_ff, b1_ff, a2_ff, b2_ff;
   logic [15:0]        u1_ff, u2_ff;
   logic signed [31:0] prod_ff, p1_ff, p2_ff, l4_ff;
   logic [MAG2_W-1:0]  mag2_5_ff, mag2_6_ff;
   logic               neg5_ff, neg6_ff;

   logic [15:0]        u_in;
   logic [16:0]        ninv;
   logic signed [16:0] bb;
   logic signed [33:0] m1, m2;
   logic [MAG_W-1:0]   mag;

   always_comb begin
      u_in = (blend > 16'd32768) ? 16'd32768 : blend;
      ninv = 17'd32768 - {1'b0, u2_ff};
      bb   = flip ? -17'(b2_ff) : 17'(b2_ff);
      m1   = 34'(a2_ff) * 34'(signed'({1'b0, ninv}));
      m2   = 34'(bb) * 34'(signed'({1'b0, u2_ff}));
      mag  = l4_ff[31] ? MAG_W'(-l4_ff) : MAG_W'(l4_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a1_ff     <= a;
         b1_ff     <= b;
         u1_ff     <= u_in;
         prod_ff   <= 32'(a * b);
         a2_ff     <= a1_ff;
         b2_ff     <= b1_ff;
         u2_ff     <= u1_ff;
         p1_ff     <= m1[31:0];
         p2_ff     <= m2[31:0];
         l4_ff     <= p1_ff + p2_ff;
         mag2_5_ff <= MAG2_W'(mag) * MAG2_W'(mag);
         neg5_ff   <= l4_ff[31];
         mag2_6_ff <= mag2_5_ff;
         neg6_ff   <= neg5_ff;
      end
   end

   // square one stage ahead of the result, for the sum-of-squares merge
   assign mag2_early  = mag2_5_ff;
   assign prod        = prod_ff;
   assign result.mag2 = mag2_6_ff;
   assign result.neg  = neg6_ff;

endmodule

### rtl/core/qnl_norm_lane.sv
// One component lane of the normaliser: bit-per-stage division by the sum of
// squares, bit-per-stage square root, rounding and saturation. Depends on qnl_pkg.
module qnl_norm_lane (
   input  logic                   clock,
   input  logic                   en,
   input  qnl_pkg::lane_mag_type  src,
   input  logic [qnl_pkg::SUM_W-1:0] sum,
   output logic [15:0]            q
);
   import qnl_pkg::*;

   logic [DREM_W-1:0] drem_ff [QUO_W];
   logic [DREM_W-1:0] drem_in [QUO_W];
   logic [QUO_W-1:0]  dquo_ff [QUO_W];
   logic [QUO_W-1:0]  dquo_in [QUO_W];
   logic [SUM_W-1:0]  dsum_ff [QUO_W];
   logic              dneg_ff [QUO_W];

   logic [SREM_W-1:0] srem_ff [ROOT_W];
   logic [SREM_W-1:0] srem_in [ROOT_W];
   logic [ROOT_W-1:0] sroot_ff [ROOT_W];
   logic [ROOT_W-1:0] sroot_in [ROOT_W];
   logic              sneg_ff [ROOT_W];

   genvar k;
   generate
      for (k = 0; k < QUO_W; k++) begin : g_div
         logic [DREM_W-1:0] prem, trial;
         logic [QUO_W-1:0]  pquo;
         logic [SUM_W-1:0]  psum;
         logic              pneg, take;
         always_comb begin
            if (k == 0) begin
               prem = DREM_W'(src.mag2) << (2 * FRAC_BITS + 2);
               pquo = '0;
               psum = sum;
               pneg = src.neg;
            end else begin
               prem = drem_ff[(k == 0) ? 0 : k - 1];
               pquo = dquo_ff[(k == 0) ? 0 : k - 1];
               psum = dsum_ff[(k == 0) ? 0 : k - 1];
               pneg = dneg_ff[(k == 0) ? 0 : k - 1];
            end
            trial      = DREM_W'(psum) << (QUO_W - 1 - k);
            take       = prem >= trial;
            drem_in[k] = take ? prem - trial : prem;
            dquo_in[k] = {pquo[QUO_W-2:0], take};
         end
         always_ff @(posedge clock) begin
            if (en) begin
               drem_ff[k] <= drem_in[k];
               dquo_ff[k] <= dquo_in[k];
               dsum_ff[k] <= psum;
               dneg_ff[k] <= pneg;
            end
         end
      end

      for (k = 0; k < ROOT_W; k++) begin : g_sqrt
         logic [SREM_W-1:0] prem, inc;
         logic [ROOT_W-1:0] proot;
         logic              pneg, take;
         always_comb begin
            if (k == 0) begin
               prem  = SREM_W'(dquo_ff[QUO_W-1]);
               proot = '0;
               pneg  = dneg_ff[QUO_W-1];
            end else begin
               prem  = srem_ff[(k == 0) ? 0 : k - 1];
               proot = sroot_ff[(k == 0) ? 0 : k - 1];
               pneg  = sneg_ff[(k == 0) ? 0 : k - 1];
            end
            inc         = (SREM_W'(proot) << (ROOT_W - k)) |
                          (SREM_W'(1) << (2 * (ROOT_W - 1 - k)));
            take        = prem >= inc;
            srem_in[k]  = take ? prem - inc : prem;
            sroot_in[k] = take ? (proot | (ROOT_W'(1) << (ROOT_W - 1 - k))) : proot;
         end
         always_ff @(posedge clock) begin
            if (en) begin
               srem_ff[k]  <= srem_in[k];
               sroot_ff[k] <= sroot_in[k];
               sneg_ff[k]  <= pneg;
            end
         end
      end
   endgenerate

   // round half up on the odd-root test: q = floor((isqrt + 1) / 2)
   logic [ROOT_W:0]   rsum;
   logic [ROOT_W-1:0] qmag;
   logic [16:0]       capped;

   always_comb begin
      rsum   = (ROOT_W + 1)'(sroot_ff[ROOT_W-1]) + 1'b1;
      qmag   = rsum[ROOT_W:1];
      capped = (40'(qmag) > 40'd32768) ? 17'd32768 : 17'(qmag);
      if (sneg_ff[ROOT_W-1]) begin
         q = 16'(-capped);
      end else begin
         q = (capped > 17'd32767) ? 16'h7fff : capped[15:0];
      end
   end

endmodule

### rtl/core/quaternion_normalized_lerp_top.sv
// Top level of the quaternion nlerp pipeline: four component lanes, the dot
// product and sum-of-squares merges, and the output register.
// Depends on qnl_pkg, qnl_blend_lane and qnl_norm_lane.
//
// Usage:
//   req channel carries one request: quaternions a, b (Q2.14) and the blend
//   factor t (Q1.15, values above one are taken as one). rsp channel returns
//   the normalised blend q (Q2.14, rounded half away from zero, saturated)
//   with tuser set when the blend had zero length and the identity is given.
//   Throughput is one request per cycle while the receiver keeps up. Each
//   request passes through six blend stages, the first loaded at acceptance,
//   one divider stage per quotient bit, one square root stage per root bit,
//   and the output register, whose valid bit drives rsp_tvalid.
//   All stages advance together; when the receiver stalls with a result
//   waiting, the whole pipeline holds and req_tready falls, and an empty
//   output register lets the pipeline move regardless of rsp_tready.
//   Reset clears every valid bit; no request is in flight afterwards.
module quaternion_normalized_lerp_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, blend (16 bits each, lowest first)
   input  logic [143:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // q_x, q_y, q_z, q_w (16 bits each, lowest first)
   output logic [63:0]  rsp_tdata,
   // zero_length
   output logic         rsp_tuser
);
   import qnl_pkg::*;

   logic                en;
   logic [PIPE_D-1:0]   vld_ff, vld_in;
   logic                rsp_valid_ff;
   logic [63:0]         rsp_data_ff;
   logic                rsp_zero_ff;

   logic signed [31:0]  prod [4];
   logic [MAG2_W-1:0]   sq [4];
   lane_mag_type        lmag [4];
   logic [15:0]         qlane [4];

   logic signed [33:0]  dot_ff;
   logic [SUM_W-1:0]    sum_ff;
   logic [QUO_W+ROOT_W-1:0] zero_ff;

   // advance whenever the output register is free or being emptied
   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   genvar i;
   generate
      for (i = 0; i < 4; i++) begin : g_lane
         qnl_blend_lane u_blend (
            .clock      (clock),
            .en         (en),
            .a          (signed'(req_tdata[16*i +: 16])),
            .b          (signed'(req_tdata[64 + 16*i +: 16])),
            .blend      (req_tdata[143:128]),
            .flip       (dot_ff[33]),
            .prod       (prod[i]),
            .mag2_early (sq[i]),
            .result     (lmag[i])
         );
         qnl_norm_lane u_norm (
            .clock (clock),
            .en    (en),
            .src   (lmag[i]),
            .sum   (sum_ff),
            .q     (qlane[i])
         );
      end
   endgenerate

   // merge: dot product of the lane terms, then the sum of squares; take the
   // squares a stage early so the sum meets each lane's square at the divider
   always_ff @(posedge clock) begin
      if (en) begin
         dot_ff  <= 34'(prod[0]) + 34'(prod[1]) + 34'(prod[2]) + 34'(prod[3]);
         sum_ff  <= SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]) + SUM_W'(sq[3]);
         zero_ff <= {zero_ff[QUO_W+ROOT_W-2:0], (sum_ff == '0)};
      end
   end

   assign vld_in = {vld_ff[PIPE_D-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff       <= vld_in;
         rsp_valid_ff <= vld_ff[PIPE_D-1];
      end
   end

   // output register: substitute the identity on a zero-length blend
   always_ff @(posedge clock) begin
      if (en) begin
         rsp_zero_ff <= zero_ff[QUO_W+ROOT_W-1];
         if (zero_ff[QUO_W+ROOT_W-1]) begin
            rsp_data_ff <= {ONE_Q, 48'd0};
         end else begin
            rsp_data_ff <= {qlane[3], qlane[2], qlane[1], qlane[0]};
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_zero_ff;

endmodule

### sim/qnl_checker.sv
// Checker for the quaternion nlerp block: watches both stream channels, predicts each
// normalised blend from the accepted request and compares it with the returned one.
// Depends on qnl_pkg for FRAC_BITS.
`timescale 1ns / 1ps

module qnl_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [143:0] req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [63:0]  rsp_tdata,
   input  logic         rsp_tuser,
   output int           fail_count,
   output int           pending
);
   import qnl_pkg::*;

   typedef struct {
      logic [15:0] q [4];
      logic        zero_length;
   } blend_result_type;

   blend_result_type expected_blends[$];

   // exact root-based scaling: largest m with (2m-1)^2 * s <= 4 * mag^2 * 2^(2F)
   function automatic longint unsigned scale_component(longint unsigned mag,
                                                       longint unsigned s);
      logic [191:0]    rhs, lhs;
      longint unsigned lo, hi, mid;
      lo  = 0;
      hi  = 32768;
      rhs = (192'(mag) * 192'(mag) * 192'd4) << (2 * FRAC_BITS);
      while (lo < hi) begin
         mid = (lo + hi + 1) / 2;
         lhs = 192'(2 * mid - 1) * 192'(2 * mid - 1) * 192'(s);
         if (lhs <= rhs) lo = mid;
         else hi = mid - 1;
      end
      return lo;
   endfunction

   function automatic blend_result_type predict_blend(logic [143:0] d);
      blend_result_type r;
      longint          a [4], b [4], l [4];
      longint          dot, t, q, bb;
      longint unsigned s, mag, one;
      dot = 0;
      s   = 0;
      for (int i = 0; i < 4; i++) begin
         a[i] = longint'($signed(d[16*i +: 16]));
         b[i] = longint'($signed(d[16*(i+4) +: 16]));
         dot += a[i] * b[i];
      end
      t = longint'(d[128 +: 16]);
      if (t > 32768) t = 32768;
      for (int i = 0; i < 4; i++) begin
         bb   = (dot < 0) ? -b[i] : b[i];
         l[i] = a[i] * (32768 - t) + bb * t;
         mag  = (l[i] < 0) ? -l[i] : l[i];
         s   += mag * mag;
      end
      if (s == 0) begin
         one = 64'd1 << FRAC_BITS;
         r.q[0] = '0; r.q[1] = '0; r.q[2] = '0;
         r.q[3] = (one > 32767) ? 16'd32767 : one[15:0];
         r.zero_length = 1'b1;
         return r;
      end
      for (int i = 0; i < 4; i++) begin
         mag = (l[i] < 0) ? -l[i] : l[i];
         q   = longint'(scale_component(mag, s));
         if (l[i] < 0) q = -q;
         if (q > 32767) q = 32767;
         if (q < -32768) q = -32768;
         r.q[i] = q[15:0];
      end
      r.zero_length = 1'b0;
      return r;
   endfunction

   function automatic string field_name(int i);
      case (i)
         0: return "q_x";
         1: return "q_y";
         2: return "q_z";
         default: return "q_w";
      endcase
   endfunction

   always @(posedge clock) begin
      blend_result_type e;
      int               errs;
      int               delta;
      errs  = 0;
      delta = 0;
      if (reset) begin
         fail_count <= 0;
         pending    <= 0;
         expected_blends.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            expected_blends.push_back(predict_blend(req_tdata));
            delta++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_blends.size() == 0) begin
               $error("unexpected response %h", rsp_tdata);
               errs++;
            end else begin
               e = expected_blends.pop_front();
               delta--;
               for (int i = 0; i < 4; i++)
                  if (rsp_tdata[16*i +: 16] !== e.q[i]) begin
                     $error("%s expected %0d actual %0d", field_name(i), $signed(e.q[i]),
                            $signed(rsp_tdata[16*i +: 16]));
                     errs++;
                  end
               if (rsp_tuser !== e.zero_length) begin
                  $error("zero_length expected %0d actual %0d", e.zero_length, rsp_tuser);
                  errs++;
               end
            end
         end
         fail_count <= fail_count + errs;
         pending    <= pending + delta;
      end
   end
endmodule

### sim/tb.sv
// Testbench top for the quaternion nlerp block: drives requests and response
// stalls, and gives the verdict from the checker's failure count.
// Depends on qnl_pkg, qnl_checker and quaternion_normalized_lerp_top.
`timescale 1ns / 1ps

module tb;
   import qnl_pkg::*;

   localparam int LATENCY = PIPE_D + 1;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, blend (16 bits each, lowest first)
   logic [143:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   // q_x, q_y, q_z, q_w (16 bits each, lowest first)
   logic [63:0]  rsp_tdata;
   // zero_length
   logic         rsp_tuser;
   int           fail_count;
   int           pending;
   bit           stall_free = 1'b0;

   always #10 clock = ~clock;

   quaternion_normalized_lerp_top DUT (.*);

   qnl_checker checker_i (.*);

   // mostly short gaps, now and then a long one
   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 80);
   endfunction

   // component with a bias towards extremes and small values
   function automatic logic [15:0] pick_component();
      case ($urandom_range(0, 9))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'(int'($urandom_range(0, 8)) - 4);
         3: return 16'h4000;
         4: return 16'hc000;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_blend();
      case ($urandom_range(0, 7))
         0: return 16'd0;
         1: return 16'd32768;
         2: return 16'($urandom_range(32769, 65535));
         default: return 16'($urandom_range(0, 32768));
      endcase
   endfunction

   // hand one request over and hold it until accepted
   task automatic send_request(input logic [143:0] d);
      int gap;
      gap = gap_length();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   function automatic logic [143:0] pack_request(logic [15:0] c [8], logic [15:0] t);
      logic [143:0] d;
      for (int i = 0; i < 8; i++) d[16*i +: 16] = c[i];
      d[128 +: 16] = t;
      return d;
   endfunction

   // randomly stall the receiver, except in stretches of free flow
   initial begin
      forever begin
         int g;
         @(posedge clock);
         if (stall_free) rsp_tready <= 1'b1;
         else begin
            g = gap_length();
            if (g > 0) begin
               rsp_tready <= 1'b0;
               repeat (g) @(posedge clock);
            end
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   initial begin
      logic [15:0] c [8];
      logic [15:0] t;
      int          n;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, zero-length blends, negative dot product, blend above one
      c = '{default: 16'h0000};
      send_request(pack_request(c, 16'd0));
      send_request(pack_request(c, 16'd32768));
      c = '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000};
      send_request(pack_request(c, 16'd16384));
      c = '{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff};
      send_request(pack_request(c, 16'hffff));
      c = '{16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff};
      send_request(pack_request(c, 16'd16384));
      // b = -a: the dot product is negative, b flips and the blend keeps a
      c = '{16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'hc000, 16'h0000, 16'h0000, 16'h0000};
      send_request(pack_request(c, 16'd16384));
      // a = -b with positive dot: impossible, so use orthogonal halves, whose blend never cancels to zero
      c = '{16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'h0000, 16'h0000};
      send_request(pack_request(c, 16'd0));
      send_request(pack_request(c, 16'd32768));
      send_request(pack_request(c, 16'd40000));
      c = '{16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h0000, 16'h4000, 16'h0000};
      send_request(pack_request(c, 16'd1));
      send_request(pack_request(c, 16'd32767));
      c = '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h4000};
      send_request(pack_request(c, 16'd32768));
      send_request(pack_request(c, 16'd0));

      // random part, with a free-flowing stretch in the middle
      for (n = 0; n < 700; n++) begin
         stall_free = (n >= 300 && n < 400);
         for (int i = 0; i < 8; i++) c[i] = pick_component();
         t = pick_blend();
         // now and then make b the negation or copy of a
         if ($urandom_range(0, 9) == 0)
            for (int i = 0; i < 4; i++) c[4+i] = -c[i];
         else if ($urandom_range(0, 9) == 0)
            for (int i = 0; i < 4; i++) c[4+i] = c[i];
         send_request(pack_request(c, t));
      end
      req_tvalid <= 1'b0;
      stall_free = 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (fail_count == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

   initial begin
      #20ms;
      $display("simulation failed");
      $finish;
   end
endmodule

### quaternion_normalized_lerp_top.f
rtl/core/qnl_pkg.sv
rtl/core/qnl_blend_lane.sv
rtl/core/qnl_norm_lane.sv
rtl/core/quaternion_normalized_lerp_top.sv
sim/qnl_checker.sv
sim/tb.sv
